FILE: rtl/ptjm_pkg.sv
// Shared types and constants for the periodic tick jitter monitor.
package ptjm_pkg;

    localparam int TIMESTAMP_BITS_DEF = 32;

    localparam int EXP_W = 44;
    localparam int SUM_W = 64;
    localparam int PER_W = 22;

    localparam logic [8:0] BPM_MIN   = 9'd20;
    localparam logic [8:0] BPM_MAX   = 9'd300;
    localparam logic [8:0] BPM_RESET = 9'd120;
    localparam logic [4:0] TPB_MIN   = 5'd1;
    localparam logic [4:0] TPB_MAX   = 5'd16;
    localparam logic [4:0] TPB_RESET = 5'd1;

    localparam logic [1:0] REG_BPM = 2'd0;
    localparam logic [1:0] REG_TPB = 2'd1;

    // 60e6 pre-aligned by 6 so that 26 quotient bits come out in the low bits
    localparam logic [31:0] PER_NUM_ALIGNED = 32'd3840000000;
    localparam logic [5:0]  PER_DIV_ITERS   = 6'd26;
    localparam logic [5:0]  AVG_DIV_ITERS   = 6'd32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PER,
        S_NOW1,
        S_NOW2,
        S_DEV,
        S_ACC,
        S_DRIFT,
        S_REBASE,
        S_AVG,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [5:0]  iters;
    } div_req_t;

endpackage

FILE: rtl/ptjm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module ptjm_div
    import ptjm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] q_reg;
    logic [31:0] divisor_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;

    always_comb
    begin
        shifted = {rem_reg, q_reg[31]};
        diff    = shifted - {1'b0, divisor_reg};
        take    = shifted >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem_init;
            q_reg       <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[31:0] : shifted[31:0];
            q_reg   <= {q_reg[30:0], take};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: rtl/periodic_tick_jitter_monitor.sv
// Top level of the periodic tick jitter monitor.
//
// One beat in gives one beat out. Stop and clear beats, starts during a run and
// ticks while stopped go straight to the output stage. A start that opens a run
// waits for the period division, a tick during a run also for the jitter steps
// and the average division (skipped when the average saturates). One shared
// bit-serial divider yields the 22-bit period from the tempo registers and then
// the 32-bit average jitter, one quotient bit per cycle. A finished result waits
// in the output register while the next beat is accepted. The period is
// recomputed for run starts and run ticks, so tempo writes take effect on the next tick.
module periodic_tick_jitter_monitor
    import ptjm_pkg::*;
#(
    parameter int TIMESTAMP_BITS = TIMESTAMP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] timestamp_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        tick_valid,
    output logic [31:0] tick_index,
    output logic [31:0] time_echo_ms,
    output logic [31:0] jitter_us,
    output logic        drift_flag,
    output logic [31:0] average_jitter_us,
    output logic [31:0] peak_jitter_us,
    output logic [31:0] missed_count,
    output logic [31:0] total_count
);

    localparam int TS_USED = (TIMESTAMP_BITS < 32) ? TIMESTAMP_BITS : 32;
    localparam logic [32:0] TS_MASK_W = (33'd1 << TS_USED) - 33'd1;

    state_t state_reg;
    state_t state_next;

    logic [8:0]       bpm_reg;
    logic [4:0]       tpb_reg;
    logic             running_reg;
    logic [31:0]      tick_counter_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [31:0]      total_reg;
    logic [31:0]      peak_reg;
    logic [31:0]      missed_reg;

    action_t          act_reg;
    logic [31:0]      ts_reg;
    logic [PER_W-1:0] per_reg;
    logic [EXP_W-1:0] now_reg;
    logic [EXP_W-1:0] dev_reg;
    logic [47:0]      dev10_reg;
    logic [EXP_W:0]   gap_reg;
    logic [31:0]      jit_reg;
    logic [31:0]      idx_reg;
    logic             drift_reg;
    logic [31:0]      avg_reg;
    logic             tick_flag_reg;

    logic             out_valid_reg;
    logic             tick_valid_reg;
    logic [31:0]      tick_index_reg;
    logic [31:0]      time_echo_reg;
    logic [31:0]      jitter_reg;
    logic             drift_out_reg;
    logic [31:0]      avg_out_reg;
    logic [31:0]      peak_out_reg;
    logic [31:0]      missed_out_reg;
    logic [31:0]      total_out_reg;

    div_req_t         div_req;
    logic             div_busy;
    logic             div_done;
    logic [31:0]      div_q;

    logic             accept;
    logic             needs_per;
    logic             out_free;
    logic             out_load;
    logic             avg_sat;
    logic [13:0]      prod;
    logic [31:0]      ts_masked;
    logic [EXP_W-1:0] ts_wide;
    logic [31:0]      jit;
    logic [SUM_W:0]   sum_add;
    logic [47:0]      dev_wide;
    logic             drift;
    logic             rebase;

    ptjm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        prod      = 14'(bpm_reg * tpb_reg);
        ts_masked = timestamp_ms & TS_MASK_W[31:0];
        ts_wide   = {12'b0, ts_reg};
        jit       = (dev_reg[EXP_W-1:32] != '0) ? 32'hFFFF_FFFF : dev_reg[31:0];
        sum_add   = {1'b0, sum_reg} + {33'b0, jit};
        dev_wide  = {4'b0, dev_reg};
        drift     = dev10_reg > {26'b0, per_reg};
        rebase    = !gap_reg[EXP_W] && (gap_reg[EXP_W-1:0] > {21'b0, per_reg, 1'b0});
        avg_sat   = sum_reg[63:32] >= total_reg;
        needs_per = ((action_t'(action) == ACT_START) && !running_reg)
                 || ((action_t'(action) == ACT_TICK) && running_reg);
        out_free  = !out_valid_reg || !out_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = needs_per ? S_PER : S_OUT;
                end
            end
            S_PER:
            begin
                if (div_done)
                begin
                    state_next = (act_reg == ACT_TICK) ? S_NOW1 : S_OUT;
                end
            end
            S_NOW1:   state_next = S_NOW2;
            S_NOW2:   state_next = S_DEV;
            S_DEV:    state_next = S_ACC;
            S_ACC:    state_next = S_DRIFT;
            S_DRIFT:  state_next = S_REBASE;
            S_REBASE: state_next = avg_sat ? S_OUT : S_AVG;
            S_AVG:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        accept   = 1'b0;
        out_load = 1'b0;
        div_req  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (in_valid && needs_per)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = PER_NUM_ALIGNED;
                    div_req.divisor  = {18'b0, prod};
                    div_req.iters    = PER_DIV_ITERS;
                end
            end
            S_REBASE:
            begin
                if (!avg_sat)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = sum_reg[63:32];
                    div_req.dividend = sum_reg[31:0];
                    div_req.divisor  = total_reg;
                    div_req.iters    = AVG_DIV_ITERS;
                end
            end
            S_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bpm_reg          <= BPM_RESET;
            tpb_reg          <= TPB_RESET;
            running_reg      <= 1'b0;
            tick_counter_reg <= '0;
            exp_reg          <= '0;
            sum_reg          <= '0;
            total_reg        <= '0;
            peak_reg         <= '0;
            missed_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BPM:
                    begin
                        if (cfg_data < BPM_MIN)
                            bpm_reg <= BPM_MIN;
                        else if (cfg_data > BPM_MAX)
                            bpm_reg <= BPM_MAX;
                        else
                            bpm_reg <= cfg_data;
                    end
                    REG_TPB:
                    begin
                        if (cfg_data[4:0] < TPB_MIN)
                            tpb_reg <= TPB_MIN;
                        else if (cfg_data[4:0] > TPB_MAX)
                            tpb_reg <= TPB_MAX;
                        else
                            tpb_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                        bpm_reg <= bpm_reg;
                    end
                endcase
            end

            if (accept)
            begin
                case (action_t'(action))
                    ACT_STOP:
                    begin
                        running_reg <= 1'b0;
                    end
                    ACT_CLEAR:
                    begin
                        sum_reg    <= '0;
                        total_reg  <= '0;
                        peak_reg   <= '0;
                        missed_reg <= '0;
                    end
                    default:
                    begin
                        running_reg <= running_reg;
                    end
                endcase
            end

            if (state_reg == S_PER && div_done && act_reg == ACT_START)
            begin
                running_reg      <= 1'b1;
                tick_counter_reg <= '0;
                sum_reg          <= '0;
                missed_reg       <= '0;
                peak_reg         <= '0;
                exp_reg          <= {22'b0, div_q[PER_W-1:0]};
            end

            if (state_reg == S_ACC)
            begin
                sum_reg          <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                if (total_reg != 32'hFFFF_FFFF)
                    total_reg <= total_reg + 32'd1;
                if (jit > peak_reg)
                    peak_reg <= jit;
                tick_counter_reg <= tick_counter_reg + 32'd1;
                exp_reg          <= exp_reg + {22'b0, per_reg};
            end

            if (state_reg == S_DRIFT && drift && missed_reg != 32'hFFFF_FFFF)
            begin
                missed_reg <= missed_reg + 32'd1;
            end

            if (state_reg == S_REBASE && rebase)
            begin
                exp_reg <= now_reg + {22'b0, per_reg};
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg       <= action_t'(action);
            ts_reg        <= ts_masked;
            tick_flag_reg <= 1'b0;
        end

        unique case (state_reg)
            S_PER:
            begin
                if (div_done)
                begin
                    per_reg       <= div_q[PER_W-1:0];
                    tick_flag_reg <= (act_reg == ACT_TICK);
                end
            end
            S_NOW1:
            begin
                now_reg <= (ts_wide << 10) - (ts_wide << 5);
            end
            S_NOW2:
            begin
                now_reg <= now_reg + (ts_wide << 3);
            end
            S_DEV:
            begin
                dev_reg <= (now_reg >= exp_reg) ? now_reg - exp_reg : exp_reg - now_reg;
            end
            S_ACC:
            begin
                jit_reg   <= jit;
                idx_reg   <= tick_counter_reg;
                dev10_reg <= (dev_wide << 3) + (dev_wide << 1);
            end
            S_DRIFT:
            begin
                drift_reg <= drift;
                gap_reg   <= {1'b0, now_reg} - {1'b0, exp_reg};
            end
            S_REBASE:
            begin
                if (avg_sat)
                    avg_reg <= 32'hFFFF_FFFF;
            end
            S_AVG:
            begin
                if (div_done)
                    avg_reg <= div_q;
            end
            default:
            begin
                per_reg <= per_reg;
            end
        endcase

        if (out_load)
        begin
            tick_valid_reg <= tick_flag_reg;
            tick_index_reg <= tick_flag_reg ? idx_reg : '0;
            time_echo_reg  <= tick_flag_reg ? ts_reg : '0;
            jitter_reg     <= tick_flag_reg ? jit_reg : '0;
            drift_out_reg  <= tick_flag_reg && drift_reg;
            avg_out_reg    <= tick_flag_reg ? avg_reg : '0;
            peak_out_reg   <= tick_flag_reg ? peak_reg : '0;
            missed_out_reg <= tick_flag_reg ? missed_reg : '0;
            total_out_reg  <= tick_flag_reg ? total_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign tick_valid        = tick_valid_reg;
    assign tick_index        = tick_index_reg;
    assign time_echo_ms      = time_echo_reg;
    assign jitter_us         = jitter_reg;
    assign drift_flag        = drift_out_reg;
    assign average_jitter_us = avg_out_reg;
    assign peak_jitter_us    = peak_out_reg;
    assign missed_count      = missed_out_reg;
    assign total_count       = total_out_reg;

    // every missed tick is also a counted tick
    assert property (@(posedge clk) disable iff (!rst_n)
        missed_reg <= total_reg)
        else $error("missed count exceeds total count");

    // the peak is one of the terms of the jitter sum
    assert property (@(posedge clk) disable iff (!rst_n)
        {32'b0, peak_reg} <= sum_reg)
        else $error("peak jitter exceeds jitter sum");

    // the shared divider is only started when free
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // a reported tick has been counted
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tick_valid_reg) |-> (total_out_reg != 32'd0))
        else $error("tick reported with zero total count");

endmodule

FILE: bench/periodic_tick_jitter_monitor_tb.sv
// Self-checking testbench for the periodic tick jitter monitor with a built-in scoreboard.
`timescale 1ns / 1ps

module periodic_tick_jitter_monitor_tb
    import ptjm_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic        tick_valid;
        logic [31:0] tick_index;
        logic [31:0] time_echo_ms;
        logic [31:0] jitter_us;
        logic        drift_flag;
        logic [31:0] average_jitter_us;
        logic [31:0] peak_jitter_us;
        logic [31:0] missed_count;
        logic [31:0] total_count;
    } tick_report_t;

    class jitter_scoreboard;
        logic [8:0]   bpm;
        logic [4:0]   tpb;
        bit           running;
        logic [31:0]  tick_num;
        logic [43:0]  next_due_us;
        logic [63:0]  jitter_sum;
        logic [31:0]  total_ticks;
        logic [31:0]  peak;
        logic [31:0]  missed;
        tick_report_t pending_reports[$];
        int           errors;

        function new();
            bpm = BPM_RESET;
            tpb = TPB_RESET;
            running = 1'b0;
            tick_num = '0;
            next_due_us = '0;
            jitter_sum = '0;
            total_ticks = '0;
            peak = '0;
            missed = '0;
            errors = 0;
        endfunction

        function logic [63:0] period_us();
            return 64'd60000000 / (64'(bpm) * 64'(tpb));
        endfunction

        function void write_reg(logic [1:0] idx, logic [8:0] data);
            case (idx)
                REG_BPM:
                begin
                    bpm = data;
                    if (data < BPM_MIN) bpm = BPM_MIN;
                    else if (data > BPM_MAX) bpm = BPM_MAX;
                end
                REG_TPB:
                begin
                    tpb = data[4:0];
                    if (data[4:0] < TPB_MIN) tpb = TPB_MIN;
                    else if (data[4:0] > TPB_MAX) tpb = TPB_MAX;
                end
                default: ;
            endcase
        endfunction

        function void note_beat(action_t act, logic [31:0] ts);
            tick_report_t r;
            logic [63:0]  per;
            logic [63:0]  now;
            logic [63:0]  due;
            logic [63:0]  dev;
            logic [63:0]  avg;
            logic [31:0]  jit;
            bit           drift;
            r = '{default: '0};
            per = period_us();
            case (act)
                ACT_START:
                begin
                    if (!running)
                    begin
                        running = 1'b1;
                        tick_num = '0;
                        jitter_sum = '0;
                        missed = '0;
                        peak = '0;
                        next_due_us = per[43:0];
                    end
                end
                ACT_STOP: running = 1'b0;
                ACT_CLEAR:
                begin
                    jitter_sum = '0;
                    total_ticks = '0;
                    peak = '0;
                    missed = '0;
                end
                default:
                begin
                    if (running)
                    begin
                        now = 64'(ts) * 64'd1000;
                        due = 64'(next_due_us);
                        dev = (now >= due) ? now - due : due - now;
                        jit = (dev > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dev[31:0];
                        drift = (dev * 64'd10) > per;
                        if (jitter_sum > ~64'd0 - 64'(jit)) jitter_sum = ~64'd0;
                        else jitter_sum = jitter_sum + 64'(jit);
                        if (total_ticks != 32'hFFFF_FFFF) total_ticks = total_ticks + 1;
                        avg = jitter_sum / 64'(total_ticks);
                        if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
                        if (jit > peak) peak = jit;
                        if (drift && missed != 32'hFFFF_FFFF) missed = missed + 1;
                        r.tick_valid = 1'b1;
                        r.tick_index = tick_num;
                        tick_num = tick_num + 1;
                        next_due_us = 44'(due + per);
                        if (now > 64'(next_due_us) && now - 64'(next_due_us) > 2 * per)
                            next_due_us = 44'(now + per);
                        r.time_echo_ms = ts;
                        r.jitter_us = jit;
                        r.drift_flag = drift;
                        r.average_jitter_us = avg[31:0];
                        r.peak_jitter_us = peak;
                        r.missed_count = missed;
                        r.total_count = total_ticks;
                    end
                end
            endcase
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(tick_report_t got);
            tick_report_t want;
            if (pending_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual tick_index %0d",
                         $time, got.tick_index);
                return;
            end
            want = pending_reports.pop_front();
            compare_field("tick_valid", 32'(want.tick_valid), 32'(got.tick_valid));
            compare_field("tick_index", want.tick_index, got.tick_index);
            compare_field("time_echo_ms", want.time_echo_ms, got.time_echo_ms);
            compare_field("jitter_us", want.jitter_us, got.jitter_us);
            compare_field("drift_flag", 32'(want.drift_flag), 32'(got.drift_flag));
            compare_field("average_jitter_us", want.average_jitter_us, got.average_jitter_us);
            compare_field("peak_jitter_us", want.peak_jitter_us, got.peak_jitter_us);
            compare_field("missed_count", want.missed_count, got.missed_count);
            compare_field("total_count", want.total_count, got.total_count);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] timestamp_ms;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        tick_valid;
    logic [31:0] tick_index;
    logic [31:0] time_echo_ms;
    logic [31:0] jitter_us;
    logic        drift_flag;
    logic [31:0] average_jitter_us;
    logic [31:0] peak_jitter_us;
    logic [31:0] missed_count;
    logic [31:0] total_count;

    bit               steady = 1'b0;
    int               cycle_count = 0;
    logic [63:0]      cursor_us;
    tick_report_t     seen;
    jitter_scoreboard sb = new();

    periodic_tick_jitter_monitor uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .timestamp_ms      (timestamp_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tick_valid        (tick_valid),
        .tick_index        (tick_index),
        .time_echo_ms      (time_echo_ms),
        .jitter_us         (jitter_us),
        .drift_flag        (drift_flag),
        .average_jitter_us (average_jitter_us),
        .peak_jitter_us    (peak_jitter_us),
        .missed_count      (missed_count),
        .total_count       (total_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.tick_valid = tick_valid;
            seen.tick_index = tick_index;
            seen.time_echo_ms = time_echo_ms;
            seen.jitter_us = jitter_us;
            seen.drift_flag = drift_flag;
            seen.average_jitter_us = average_jitter_us;
            seen.peak_jitter_us = peak_jitter_us;
            seen.missed_count = missed_count;
            seen.total_count = total_count;
            sb.check_report(seen);
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_beat(action_t act, logic [31:0] ts);
        if (!steady && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < 36);
        end
        in_valid <= 1'b1;
        action <= act;
        timestamp_ms <= ts;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_beat(act, ts);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(negedge clk);
    endtask

    task automatic set_tempo(logic [8:0] bpm_raw, logic [8:0] tpb_raw);
        logic [1:0] spare;
        logic [8:0] junk;
        spare = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
        junk = 9'($urandom);
        cfg_write <= 1'b1;
        cfg_index <= REG_BPM;
        cfg_data <= bpm_raw;
        @(posedge clk);
        sb.write_reg(REG_BPM, bpm_raw);
        @(negedge clk);
        cfg_index <= REG_TPB;
        cfg_data <= tpb_raw;
        @(posedge clk);
        sb.write_reg(REG_TPB, tpb_raw);
        @(negedge clk);
        cfg_index <= spare;
        cfg_data <= junk;
        @(posedge clk);
        sb.write_reg(spare, junk);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Default tempo of 120 bpm: period 500 ms, drift threshold 50 ms.
    task automatic run_directed();
        send_beat(ACT_TICK, 32'd0);
        send_beat(ACT_STOP, 32'hFFFF_FFFF);
        send_beat(ACT_CLEAR, 32'd0);
        send_beat(ACT_START, 32'd0);
        send_beat(ACT_TICK, 32'd550);
        send_beat(ACT_TICK, 32'd1051);
        send_beat(ACT_TICK, 32'd1500);
        send_beat(ACT_TICK, 32'd1951);
        send_beat(ACT_TICK, 32'd4000);
        send_beat(ACT_TICK, 32'd5600);
        send_beat(ACT_START, 32'd0);
        send_beat(ACT_TICK, 32'd0);
        send_beat(ACT_TICK, 32'hFFFF_FFFF);
        send_beat(ACT_CLEAR, 32'd0);
        send_beat(ACT_TICK, 32'd7000);
        send_beat(ACT_STOP, 32'd0);
        send_beat(ACT_STOP, 32'd0);
        send_beat(ACT_TICK, 32'hFFFF_FFFF);
        send_beat(ACT_START, 32'd0);
        send_beat(ACT_TICK, 32'hAAAA_AAAA);
        send_beat(ACT_TICK, 32'h5555_5555);
        send_beat(ACT_CLEAR, 32'd0);
    endtask

    // Mostly runs of ticks near the ideal grid, with skips, starts, stops, clears and noise.
    task automatic run_random(int count);
        logic [63:0] per;
        longint      ts_ms;
        int          spread;
        int          wob;
        int          pick;
        int          r;
        repeat (count)
        begin
            per = sb.period_us();
            r = $urandom_range(99);
            if (r < 3)
            begin
                if (!sb.running) cursor_us = '0;
                send_beat(ACT_START, $urandom);
            end
            else if (r < 6)
                send_beat(ACT_STOP, $urandom);
            else if (r < 9)
                send_beat(ACT_CLEAR, $urandom);
            else if (r < 15)
                send_beat(ACT_TICK, $urandom);
            else if (!sb.running)
            begin
                cursor_us = '0;
                send_beat(ACT_START, $urandom);
            end
            else
            begin
                cursor_us = cursor_us + per;
                pick = $urandom_range(99);
                if (pick < 10) cursor_us = cursor_us + per * $urandom_range(2, 4);
                spread = (pick < 70) ? int'(per / 20000) + 1 : int'(per / 4000) + 1;
                wob = int'($urandom_range(0, 2 * spread)) - spread;
                ts_ms = longint'(cursor_us / 1000) + wob;
                if (ts_ms < 0) ts_ms = 0;
                send_beat(ACT_TICK, ts_ms[31:0]);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_BPM;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_TICK;
        timestamp_ms = '0;
        cursor_us = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0: set_tempo(9'd0, 9'd0);
                1: set_tempo(9'd511, 9'd31);
                2: set_tempo(9'd300, 9'd16);
                3: set_tempo(9'd20, 9'd1);
                4: set_tempo(9'd19, 9'd17);
                5: set_tempo(9'd301, 9'h1E0);
                default: set_tempo(9'($urandom), 9'($urandom));
            endcase
            steady = (phase == 4);
            run_random(110);
            steady = 1'b0;
        end
        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
